// ----- rtl/mpe_pkg.sv -----
// shared types, codes and floating-point helper functions of the equilibration block
package mpe_pkg;

   localparam int ROWS_MAX = 16;
   localparam int COLS_MAX = 16;
   localparam int ROW_W    = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam int COL_W    = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
   localparam int DEPTH    = ROWS_MAX * COLS_MAX;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_W    = 5;
   localparam int MAG_W    = 63;

   localparam logic [1:0] KIND_ROW = 2'd0;
   localparam logic [1:0] KIND_COL = 2'd1;
   localparam logic [1:0] KIND_SUM = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZROW = 2'd1;
   localparam logic [1:0] STATUS_ZCOL = 2'd2;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_SCALE = 2'd1;
   localparam logic [1:0] OP_LOG2  = 2'd2;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   localparam logic [MAG_W-1:0] MAG_INF = {11'h7FF, 52'd0};
   localparam logic [MAG_W-1:0] MAG_NAN = {11'h7FF, 1'b1, 51'd0};
   localparam logic signed [11:0] AMAX_NONE = -12'sd1074;

   typedef struct packed {
      logic [1:0]          op;
      logic [MAG_W-1:0]    a;
      logic [MAG_W-1:0]    b;
      logic signed [10:0]  sexp;
   } fpu_req_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic             clear;
   } cfg_type;

   // leading zeros of a 53-bit mantissa
   function automatic logic [5:0] lzc53(input logic [52:0] v);
      logic [5:0] n;
      n = 6'd53;
      for (int i = 0; i < 53; i++) begin
         if (v[i]) n = 6'(52 - i);
      end
      return n;
   endfunction

   // right shift keeping the lost bits as a sticky lsb
   function automatic logic [55:0] shr_sticky(input logic [55:0] v, input logic [5:0] sh);
      logic [55:0] r;
      logic        st;
      r  = v >> sh;
      st = |(v & ~({56{1'b1}} << sh));
      return {r[55:1], r[0] | st};
   endfunction

   // round to nearest even, three guard bits at the bottom
   function automatic logic [53:0] rnd56(input logic [55:0] v);
      logic up;
      up = v[2] & (v[1] | v[0] | v[3]);
      return {1'b0, v[55:3]} + 54'(up);
   endfunction

   // a > b for non-negative doubles, nan never wins
   function automatic logic mag_gt(input logic [MAG_W-1:0] a, input logic [MAG_W-1:0] b);
      logic nan_a;
      nan_a = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      return !nan_a && (a > b);
   endfunction

   function automatic logic signed [10:0] clamp1022(input logic signed [11:0] k);
      logic signed [10:0] r;
      if (k < -12'sd1022)     r = -11'sd1022;
      else if (k > 12'sd1022) r = 11'sd1022;
      else                    r = k[10:0];
      return r;
   endfunction

   function automatic logic signed [11:0] cond_exp(input logic signed [11:0] kmin,
                                                   input logic signed [11:0] kmax);
      logic signed [10:0] lo;
      logic signed [10:0] hi;
      lo = clamp1022(kmin);
      hi = clamp1022(kmax);
      return {lo[10], lo} - {hi[10], hi};
   endfunction

endpackage

// ----- rtl/mpe_req_if.sv -----
// element channel: one complex element as two double bit patterns
interface mpe_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] re_bits;
   logic [63:0] im_bits;

   modport source (output valid, re_bits, im_bits, input ready);
   modport sink   (input valid, re_bits, im_bits, output ready);
endinterface

// ----- rtl/mpe_rsp_if.sv -----
// result channel: scale factors and the final summary
interface mpe_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [3:0]         index;
   logic signed [10:0] scale_exp;
   logic [1:0]         status;
   logic [3:0]         bad_index;
   logic signed [11:0] amax_exp;
   logic signed [11:0] rowcnd_exp;
   logic signed [11:0] colcnd_exp;
   logic               last;

   modport source (output valid, kind, index, scale_exp, status, bad_index, amax_exp,
                   rowcnd_exp, colcnd_exp, last, input ready);
   modport sink   (input valid, kind, index, scale_exp, status, bad_index, amax_exp,
                   rowcnd_exp, colcnd_exp, last, output ready);
endinterface

// ----- rtl/matrix_pow2_equilibration.sv -----
// top level: element intake, row and column passes, result sequencing
//
// Elements of a rows x cols complex matrix arrive on req in column-major
// order, one word per element, re and im as double bit patterns. Each
// element is accepted in S_LOAD; in S_ADD the block uses the shared double
// unit to form |re|+|im|, writes it to the magnitude ram and folds it into
// its row maximum; ready is low during S_ADD. After the last element (m
// rows, n columns) the block takes the log2 of each row maximum in the
// shared double unit, closes the row pass, emits the row words, then for
// each stored element reads the ram, then scales and compares the
// magnitude, takes each column log2, closes the column pass and emits the
// column words and the summary word. Row and column factors and the
// summary leave through one output register on rsp; while rsp stalls the
// sequencer holds in whichever state is emitting a word.
// A zero row yields only the summary; a zero column yields the row words
// and the summary. The run then restarts for the next matrix.
// Reset is synchronous: dimensions return to 16 x 16, the row maxima and
// element counters clear; the magnitude ram is not cleared, every entry is
// written before it is read. A csr write also restarts the run.
module matrix_pow2_equilibration (
   input  logic        clock,
   input  logic        reset,
   mpe_req_if.sink     req,
   mpe_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int RW = mpe_pkg::ROW_W;
   localparam int CW = mpe_pkg::COL_W;
   localparam int AW = mpe_pkg::ADDR_W;

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_ADD    = 4'd1;
   localparam logic [3:0] S_ROW    = 4'd2;
   localparam logic [3:0] S_ROWEND = 4'd3;
   localparam logic [3:0] S_EMITR  = 4'd4;
   localparam logic [3:0] S_CRD    = 4'd5;
   localparam logic [3:0] S_CCMP   = 4'd6;
   localparam logic [3:0] S_CFIN   = 4'd7;
   localparam logic [3:0] S_COLEND = 4'd8;
   localparam logic [3:0] S_EMITC  = 4'd9;
   localparam logic [3:0] S_SUM    = 4'd10;

   mpe_pkg::cfg_type     cfg;
   mpe_pkg::fpu_req_type fpu_req;
   logic [62:0]          fpu_bits;
   logic signed [11:0]   fpu_log;
   logic [62:0]          ram_rdata;
   logic                 ram_we;

   logic [3:0]          state_ff, state_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [63:0]         re_ff, re_in, im_ff, im_in;
   logic [62:0]         rowmax_ff [mpe_pkg::ROWS_MAX];
   logic [62:0]         rowmax_in [mpe_pkg::ROWS_MAX];
   logic signed [10:0]  rse_ff [mpe_pkg::ROWS_MAX];
   logic signed [10:0]  rse_in [mpe_pkg::ROWS_MAX];
   logic signed [10:0]  cexp_ff [mpe_pkg::COLS_MAX];
   logic signed [10:0]  cexp_in [mpe_pkg::COLS_MAX];
   logic [62:0]         colmax_ff, colmax_in;
   logic signed [11:0]  kmax_ff, kmax_in, kmin_ff, kmin_in;
   logic                have_ff, have_in, zero_ff, zero_in;
   logic [3:0]          bad_ff, bad_in;
   logic [1:0]          status_ff, status_in;
   logic signed [11:0]  amax_ff, amax_in, rowcnd_ff, rowcnd_in, colcnd_ff, colcnd_in;
   logic                rvalid_ff, rvalid_in;
   logic [1:0]          okind_ff, okind_in;
   logic [3:0]          oindex_ff, oindex_in;
   logic signed [10:0]  oscale_ff, oscale_in;
   logic [1:0]          ostatus_ff, ostatus_in;
   logic [3:0]          obad_ff, obad_in;
   logic signed [11:0]  oamax_ff, oamax_in, orowc_ff, orowc_in, ocolc_ff, ocolc_in;
   logic                olast_ff, olast_in;
   logic                out_free, out_load, row_last, col_last;

   mpe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );
   assign csr_pready = 1'b1;

   mpe_fpu u_fpu (
      .req_i    (fpu_req),
      .res_bits (fpu_bits),
      .res_log  (fpu_log)
   );

   mpe_ram #(.WIDTH(mpe_pkg::MAG_W), .DEPTH(mpe_pkg::DEPTH)) u_mag_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (fpu_bits),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign row_last = (row_ff == RW'(cfg.rows - 5'd1));
   assign col_last = (col_ff == CW'(cfg.cols - 5'd1));
   assign out_free = !rvalid_ff || rsp.ready;
   assign req.ready = (state_ff == S_LOAD);
   assign ram_we    = (state_ff == S_ADD);

   // operand selection for the shared unit
   always_comb begin
      fpu_req.op   = mpe_pkg::OP_ADD;
      fpu_req.a    = re_ff[62:0];
      fpu_req.b    = im_ff[62:0];
      fpu_req.sexp = rse_ff[row_ff];
      unique case (state_ff)
         S_ROW: begin
            fpu_req.op = mpe_pkg::OP_LOG2;
            fpu_req.a  = rowmax_ff[row_ff];
         end
         S_CCMP: begin
            fpu_req.op = mpe_pkg::OP_SCALE;
            fpu_req.a  = ram_rdata;
         end
         S_CFIN: begin
            fpu_req.op = mpe_pkg::OP_LOG2;
            fpu_req.a  = colmax_ff;
         end
         default: fpu_req.op = mpe_pkg::OP_ADD;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      addr_in   = addr_ff;
      re_in     = re_ff;
      im_in     = im_ff;
      rowmax_in = rowmax_ff;
      rse_in    = rse_ff;
      cexp_in   = cexp_ff;
      colmax_in = colmax_ff;
      kmax_in   = kmax_ff;
      kmin_in   = kmin_ff;
      have_in   = have_ff;
      zero_in   = zero_ff;
      bad_in    = bad_ff;
      status_in = status_ff;
      amax_in   = amax_ff;
      rowcnd_in = rowcnd_ff;
      colcnd_in = colcnd_ff;
      out_load  = 1'b0;
      okind_in  = okind_ff;
      oindex_in = oindex_ff;
      oscale_in = oscale_ff;
      ostatus_in = ostatus_ff;
      obad_in   = obad_ff;
      oamax_in  = oamax_ff;
      orowc_in  = orowc_ff;
      ocolc_in  = ocolc_ff;
      olast_in  = olast_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req.valid) begin
               re_in    = req.re_bits;
               im_in    = req.im_bits;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (mpe_pkg::mag_gt(fpu_bits, rowmax_ff[row_ff])) rowmax_in[row_ff] = fpu_bits;
            if (row_last && col_last) begin
               row_in   = '0;
               col_in   = '0;
               addr_in  = '0;
               have_in  = 1'b0;
               zero_in  = 1'b0;
               bad_in   = '0;
               state_in = S_ROW;
            end else begin
               addr_in  = addr_ff + AW'(1);
               state_in = S_LOAD;
               if (row_last) begin
                  row_in = '0;
                  col_in = col_ff + CW'(1);
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end
         end
         S_ROW: begin
            if (rowmax_ff[row_ff] != 63'd0) begin
               kmax_in = (!have_ff || fpu_log > kmax_ff) ? fpu_log : kmax_ff;
               kmin_in = (!have_ff || fpu_log < kmin_ff) ? fpu_log : kmin_ff;
               have_in = 1'b1;
               rse_in[row_ff] = -mpe_pkg::clamp1022(fpu_log);
            end else if (!zero_ff) begin
               zero_in = 1'b1;
               bad_in  = 4'(row_ff);
            end
            if (row_last) begin
               row_in   = '0;
               state_in = S_ROWEND;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         S_ROWEND: begin
            amax_in   = have_ff ? kmax_ff : mpe_pkg::AMAX_NONE;
            rowcnd_in = mpe_pkg::cond_exp(kmin_ff, kmax_ff);
            have_in   = 1'b0;
            if (zero_ff) begin
               status_in = mpe_pkg::STATUS_ZROW;
               state_in  = S_SUM;
            end else begin
               status_in = mpe_pkg::STATUS_OK;
               state_in  = S_EMITR;
            end
         end
         S_EMITR: begin
            if (out_free) begin
               out_load   = 1'b1;
               okind_in   = mpe_pkg::KIND_ROW;
               oindex_in  = 4'(row_ff);
               oscale_in  = rse_ff[row_ff];
               ostatus_in = mpe_pkg::STATUS_OK;
               obad_in    = '0;
               oamax_in   = '0;
               orowc_in   = '0;
               ocolc_in   = '0;
               olast_in   = 1'b0;
               if (row_last) begin
                  row_in    = '0;
                  col_in    = '0;
                  addr_in   = '0;
                  colmax_in = '0;
                  state_in  = S_CRD;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end
         end
         S_CRD: state_in = S_CCMP;
         S_CCMP: begin
            if (mpe_pkg::mag_gt(fpu_bits, colmax_ff)) colmax_in = fpu_bits;
            addr_in = addr_ff + AW'(1);
            if (row_last) begin
               row_in   = '0;
               state_in = S_CFIN;
            end else begin
               row_in   = row_ff + RW'(1);
               state_in = S_CRD;
            end
         end
         S_CFIN: begin
            if (colmax_ff != 63'd0) begin
               kmax_in = (!have_ff || fpu_log > kmax_ff) ? fpu_log : kmax_ff;
               kmin_in = (!have_ff || fpu_log < kmin_ff) ? fpu_log : kmin_ff;
               have_in = 1'b1;
               cexp_in[col_ff] = -mpe_pkg::clamp1022(fpu_log);
            end else begin
               cexp_in[col_ff] = '0;
               if (!zero_ff) begin
                  zero_in = 1'b1;
                  bad_in  = 4'(col_ff);
               end
            end
            colmax_in = '0;
            if (col_last) begin
               col_in   = '0;
               state_in = S_COLEND;
            end else begin
               col_in   = col_ff + CW'(1);
               state_in = S_CRD;
            end
         end
         S_COLEND: begin
            colcnd_in = mpe_pkg::cond_exp(kmin_ff, kmax_ff);
            if (zero_ff) begin
               status_in = mpe_pkg::STATUS_ZCOL;
               state_in  = S_SUM;
            end else begin
               state_in = S_EMITC;
            end
         end
         S_EMITC: begin
            if (out_free) begin
               out_load   = 1'b1;
               okind_in   = mpe_pkg::KIND_COL;
               oindex_in  = 4'(col_ff);
               oscale_in  = cexp_ff[col_ff];
               ostatus_in = mpe_pkg::STATUS_OK;
               obad_in    = '0;
               oamax_in   = '0;
               orowc_in   = '0;
               ocolc_in   = '0;
               olast_in   = 1'b0;
               if (col_last) begin
                  col_in   = '0;
                  state_in = S_SUM;
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         S_SUM: begin
            if (out_free) begin
               out_load   = 1'b1;
               okind_in   = mpe_pkg::KIND_SUM;
               oindex_in  = '0;
               oscale_in  = '0;
               ostatus_in = status_ff;
               obad_in    = (status_ff == mpe_pkg::STATUS_OK) ? 4'd0 : bad_ff;
               oamax_in   = amax_ff;
               orowc_in   = (status_ff == mpe_pkg::STATUS_ZROW) ? 12'sd0 : rowcnd_ff;
               ocolc_in   = (status_ff == mpe_pkg::STATUS_OK) ? colcnd_ff : 12'sd0;
               olast_in   = 1'b1;
               // next matrix starts from scratch
               for (int i = 0; i < mpe_pkg::ROWS_MAX; i++) rowmax_in[i] = '0;
               row_in    = '0;
               col_in    = '0;
               addr_in   = '0;
               colmax_in = '0;
               state_in  = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase

      if (cfg.clear) begin
         for (int i = 0; i < mpe_pkg::ROWS_MAX; i++) rowmax_in[i] = '0;
         row_in    = '0;
         col_in    = '0;
         addr_in   = '0;
         colmax_in = '0;
         state_in  = S_LOAD;
      end

      if (out_load)       rvalid_in = 1'b1;
      else if (rsp.ready) rvalid_in = 1'b0;
      else                rvalid_in = rvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         row_ff    <= '0;
         col_ff    <= '0;
         addr_ff   <= '0;
         colmax_ff <= '0;
         have_ff   <= 1'b0;
         zero_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < mpe_pkg::ROWS_MAX; i++) rowmax_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         addr_ff   <= addr_in;
         colmax_ff <= colmax_in;
         have_ff   <= have_in;
         zero_ff   <= zero_in;
         rvalid_ff <= rvalid_in;
         rowmax_ff <= rowmax_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff      <= re_in;
      im_ff      <= im_in;
      rse_ff     <= rse_in;
      cexp_ff    <= cexp_in;
      kmax_ff    <= kmax_in;
      kmin_ff    <= kmin_in;
      bad_ff     <= bad_in;
      status_ff  <= status_in;
      amax_ff    <= amax_in;
      rowcnd_ff  <= rowcnd_in;
      colcnd_ff  <= colcnd_in;
      okind_ff   <= okind_in;
      oindex_ff  <= oindex_in;
      oscale_ff  <= oscale_in;
      ostatus_ff <= ostatus_in;
      obad_ff    <= obad_in;
      oamax_ff   <= oamax_in;
      orowc_ff   <= orowc_in;
      ocolc_ff   <= ocolc_in;
      olast_ff   <= olast_in;
   end

   assign rsp.valid      = rvalid_ff;
   assign rsp.kind       = okind_ff;
   assign rsp.index      = oindex_ff;
   assign rsp.scale_exp  = oscale_ff;
   assign rsp.status     = ostatus_ff;
   assign rsp.bad_index  = obad_ff;
   assign rsp.amax_exp   = oamax_ff;
   assign rsp.rowcnd_exp = orowc_ff;
   assign rsp.colcnd_exp = ocolc_ff;
   assign rsp.last       = olast_ff;

`ifndef SYNTHESIS
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.last == (rsp.kind == mpe_pkg::KIND_SUM)))
      else $error("last flag disagrees with word kind");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMITR || state_ff == S_ROW) |-> (5'(row_ff) < cfg.rows))
      else $error("row index beyond the rows in use");

   a_no_col_after_zero: assert property (@(posedge clock) disable iff (reset)
      (out_load && okind_in == mpe_pkg::KIND_COL) |-> !zero_ff)
      else $error("column factor issued after a zero row or column");
`endif
endmodule

// ----- rtl/mpe_ram.sv -----
// generic single-write, single-read ram with registered read data
module mpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ----- rtl/mpe_csr.sv -----
// apb register block holding the problem dimensions
module mpe_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output mpe_pkg::cfg_type cfg
);
   logic [4:0] rows_ff, rows_in;
   logic [4:0] cols_ff, cols_in;
   logic       wr;

   function automatic logic [4:0] eff_dim(input logic [4:0] v, input logic [4:0] mx);
      logic [4:0] r;
      if (v == 5'd0)   r = 5'd1;
      else if (v > mx) r = mx;
      else             r = v;
      return r;
   endfunction

   assign wr = psel && penable && pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr) begin
         unique case (paddr[2])
            mpe_pkg::REG_ROWS: rows_in = pwdata[4:0];
            mpe_pkg::REG_COLS: cols_in = pwdata[4:0];
            default:           rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 5'd16;
         cols_ff <= 5'd16;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign prdata    = (paddr[2] == mpe_pkg::REG_COLS) ? {27'd0, cols_ff} : {27'd0, rows_ff};
   assign cfg.rows  = eff_dim(rows_ff, 5'(mpe_pkg::ROWS_MAX));
   assign cfg.cols  = eff_dim(cols_ff, 5'(mpe_pkg::COLS_MAX));
   assign cfg.clear = wr;
endmodule

// ----- rtl/mpe_fpu.sv -----
// shared double unit: magnitude add, power-of-two scaling, truncated log2
module mpe_fpu (
   input  mpe_pkg::fpu_req_type req_i,
   output logic [62:0]          res_bits,
   output logic signed [11:0]   res_log
);
   always_comb begin
      logic [10:0]        ea, eb, exf, eyf;
      logic [51:0]        fa, fb;
      logic               a_nan, b_nan, a_inf, b_inf;
      logic [62:0]        x, y;
      logic [52:0]        mx, my, ma, mn;
      logic [10:0]        d;
      logic [5:0]         sh, lz;
      logic [55:0]        v;
      logic [56:0]        sum;
      logic [11:0]        e12;
      logic [53:0]        r;
      logic [52:0]        mant;
      logic signed [12:0] en, er, shs;
      logic signed [11:0] fl;
      logic               pow2;

      ea  = req_i.a[62:52];
      eb  = req_i.b[62:52];
      fa  = req_i.a[51:0];
      fb  = req_i.b[51:0];
      a_nan = (ea == 11'h7FF) && (fa != 52'd0);
      b_nan = (eb == 11'h7FF) && (fb != 52'd0);
      a_inf = (ea == 11'h7FF) && (fa == 52'd0);
      b_inf = (eb == 11'h7FF) && (fb == 52'd0);
      x = req_i.a; y = req_i.b;
      exf = 11'd1; eyf = 11'd1;
      mx = '0; my = '0; ma = '0; mn = '0;
      d = '0; sh = '0; lz = '0; v = '0; sum = '0; e12 = '0; r = '0; mant = '0;
      en = '0; er = '0; shs = '0; fl = '0; pow2 = 1'b0;
      res_bits = '0;
      res_log  = '0;

      unique case (req_i.op)
         mpe_pkg::OP_ADD: begin
            if (a_nan || b_nan) res_bits = mpe_pkg::MAG_NAN;
            else if (a_inf || b_inf) res_bits = mpe_pkg::MAG_INF;
            else begin
               if (req_i.a < req_i.b) begin
                  x = req_i.b; y = req_i.a;
               end
               exf = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
               eyf = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
               mx  = {x[62:52] != 11'd0, x[51:0]};
               my  = {y[62:52] != 11'd0, y[51:0]};
               d   = exf - eyf;
               sh  = (d >= 11'd56) ? 6'd56 : d[5:0];
               sum = {1'b0, mx, 3'b000} + {1'b0, shr_sticky_w({my, 3'b000}, sh)};
               if (sum[56]) begin
                  v   = {sum[56:2], sum[1] | sum[0]};
                  e12 = {1'b0, exf} + 12'd1;
               end else begin
                  v   = sum[55:0];
                  e12 = {1'b0, exf};
               end
               r = mpe_pkg::rnd56(v);
               if (r[53]) begin
                  mant = r[53:1];
                  e12  = e12 + 12'd1;
               end else begin
                  mant = r[52:0];
               end
               if (e12 >= 12'd2047) res_bits = mpe_pkg::MAG_INF;
               else res_bits = {mant[52] ? e12[10:0] : 11'd0, mant[51:0]};
            end
         end
         mpe_pkg::OP_SCALE: begin
            if (a_nan) res_bits = mpe_pkg::MAG_NAN;
            else if (a_inf) res_bits = mpe_pkg::MAG_INF;
            else if (req_i.a == 63'd0) res_bits = '0;
            else begin
               ma  = {ea != 11'd0, fa};
               lz  = mpe_pkg::lzc53(ma);
               mn  = ma << lz;
               en  = $signed({2'b00, (ea == 11'd0) ? 11'd1 : ea}) - $signed({7'd0, lz});
               er  = en + {{2{req_i.sexp[10]}}, req_i.sexp};
               if (er >= 13'sd2047) res_bits = mpe_pkg::MAG_INF;
               else if (er >= 13'sd1) res_bits = {er[10:0], mn[51:0]};
               else begin
                  // result lands in the subnormal range
                  shs = 13'sd1 - er;
                  sh  = (shs >= 13'sd56) ? 6'd56 : shs[5:0];
                  v   = shr_sticky_w({mn, 3'b000}, sh);
                  r   = mpe_pkg::rnd56(v);
                  res_bits = {10'd0, r[52:0]};
               end
            end
         end
         mpe_pkg::OP_LOG2: begin
            if (ea == 11'h7FF) res_log = 12'sd1023;
            else begin
               if (ea == 11'd0) begin
                  lz   = mpe_pkg::lzc53({1'b0, fa});
                  fl   = -12'sd1022 - $signed({6'd0, lz});
                  pow2 = ((fa & (fa - 52'd1)) == 52'd0);
               end else begin
                  fl   = $signed({1'b0, ea}) - 12'sd1023;
                  pow2 = (fa == 52'd0);
               end
               res_log = (fl >= 12'sd0 || pow2) ? fl : fl + 12'sd1;
            end
         end
         default: res_bits = '0;
      endcase
   end

   function automatic logic [55:0] shr_sticky_w(input logic [55:0] val, input logic [5:0] s);
      return mpe_pkg::shr_sticky(val, s);
   endfunction
endmodule

// ----- sim/mpe_checker.sv -----
// result checker: predicts equilibration factors from accepted words and compares them
module mpe_checker (
   input  logic        clock,
   input  logic        reset,
   mpe_req_if          req,
   mpe_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fails,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]         kind;
      logic [3:0]         index;
      logic signed [10:0] scale_exp;
      logic [1:0]         status;
      logic [3:0]         bad_index;
      logic signed [11:0] amax_exp;
      logic signed [11:0] rowcnd_exp;
      logic signed [11:0] colcnd_exp;
      logic               last;
   } factor_word;

   factor_word factor_queue[$];

   logic [mpe_pkg::MAG_W-1:0] mag_ram [mpe_pkg::DEPTH];
   logic [mpe_pkg::MAG_W-1:0] row_peak [mpe_pkg::ROWS_MAX];
   int               row_shift [mpe_pkg::ROWS_MAX];
   int               elem_count;
   logic [4:0]       rows_reg;
   logic [4:0]       cols_reg;

   assign pending = factor_queue.size();

   function automatic real as_real(input logic [mpe_pkg::MAG_W-1:0] b);
      return $bitstoreal({1'b0, b});
   endfunction

   // trunc(log2 x) for positive magnitudes, infinity saturates
   function automatic int log2_trunc(input logic [mpe_pkg::MAG_W-1:0] b);
      logic [10:0] e;
      logic [51:0] f;
      int          fl;
      int          msb;
      logic        pow2;
      e = b[62:52];
      f = b[51:0];
      if (e == 11'h7FF) return 1023;
      if (e == 11'd0) begin
         msb = 0;
         for (int t = 0; t < 52; t++) if (f[t]) msb = t;
         fl   = msb - 1074;
         pow2 = (f & (f - 52'd1)) == 52'd0;
      end else begin
         fl   = int'(e) - 1023;
         pow2 = (f == 52'd0);
      end
      return (fl >= 0 || pow2) ? fl : fl + 1;
   endfunction

   function automatic int clamp_exp(input int k);
      if (k < -1022) return -1022;
      if (k > 1022) return 1022;
      return k;
   endfunction

   function automatic int dim_of(input logic [4:0] v, input int mx);
      if (v == 5'd0) return 1;
      if (int'(v) > mx) return mx;
      return int'(v);
   endfunction

   function automatic factor_word mk_word(input logic [1:0] kind, input int idx, input int sc,
                                          input logic [1:0] st, input int bad, input int am,
                                          input int rc, input int cc, input logic lst);
      factor_word w;
      w.kind = kind;
      w.index = 4'(idx);
      w.scale_exp = 11'(sc);
      w.status = st;
      w.bad_index = 4'(bad);
      w.amax_exp = 12'(am);
      w.rowcnd_exp = 12'(rc);
      w.colcnd_exp = 12'(cc);
      w.last = lst;
      return w;
   endfunction

   task automatic clear_run();
      elem_count = 0;
      for (int i = 0; i < mpe_pkg::ROWS_MAX; i++) row_peak[i] = '0;
   endtask

   task automatic take_element(input logic [63:0] re, input logic [63:0] im);
      int          m;
      int          n;
      int          pos;
      int          ri;
      int          kmax;
      int          kmin;
      int          k;
      int          amax;
      int          rowcnd;
      int          bad;
      bit          have;
      bit          zero_found;
      real         mag;
      real         s;
      logic [63:0] mbits;
      logic [mpe_pkg::MAG_W-1:0] cmax;
      int          col_shift [mpe_pkg::COLS_MAX];
      m = dim_of(rows_reg, mpe_pkg::ROWS_MAX);
      n = dim_of(cols_reg, mpe_pkg::COLS_MAX);
      pos = elem_count;
      if (pos >= m * n) pos = 0;
      mag = as_real(re[62:0]) + as_real(im[62:0]);
      mbits = $realtobits(mag);
      mag_ram[pos] = mbits[62:0];
      ri = pos % m;
      if (mag > as_real(row_peak[ri])) row_peak[ri] = mbits[62:0];
      elem_count = pos + 1;
      if (elem_count < m * n) return;

      have = 0; zero_found = 0; bad = 0; kmax = 0; kmin = 0;
      for (int i = 0; i < m; i++) begin
         if (as_real(row_peak[i]) > 0.0) begin
            k = log2_trunc(row_peak[i]);
            if (!have || k > kmax) kmax = k;
            if (!have || k < kmin) kmin = k;
            have = 1;
            row_shift[i] = -clamp_exp(k);
         end else if (!zero_found) begin
            zero_found = 1;
            bad = i;
         end
      end
      amax = have ? kmax : -1074;
      if (zero_found) begin
         factor_queue.push_back(mk_word(mpe_pkg::KIND_SUM, 0, 0, mpe_pkg::STATUS_ZROW, bad,
                                        amax, 0, 0, 1'b1));
         clear_run();
         return;
      end
      rowcnd = clamp_exp(kmin) - clamp_exp(kmax);
      for (int i = 0; i < m; i++)
         factor_queue.push_back(mk_word(mpe_pkg::KIND_ROW, i, row_shift[i],
                                        mpe_pkg::STATUS_OK, 0, 0, 0, 0, 1'b0));

      // column pass on the row-scaled magnitudes
      have = 0;
      for (int j = 0; j < n; j++) begin
         cmax = '0;
         for (int i = 0; i < m; i++) begin
            s = as_real(mag_ram[j * m + i])
                * $bitstoreal({1'b0, 11'(clamp_exp(row_shift[i]) + 1023), 52'd0});
            if (s > as_real(cmax)) begin
               mbits = $realtobits(s);
               cmax = mbits[62:0];
            end
         end
         if (as_real(cmax) > 0.0) begin
            k = log2_trunc(cmax);
            if (!have || k > kmax) kmax = k;
            if (!have || k < kmin) kmin = k;
            have = 1;
            col_shift[j] = -clamp_exp(k);
         end else begin
            col_shift[j] = 0;
            if (!zero_found) begin
               zero_found = 1;
               bad = j;
            end
         end
      end
      if (zero_found) begin
         factor_queue.push_back(mk_word(mpe_pkg::KIND_SUM, 0, 0, mpe_pkg::STATUS_ZCOL, bad,
                                        amax, rowcnd, 0, 1'b1));
      end else begin
         for (int j = 0; j < n; j++)
            factor_queue.push_back(mk_word(mpe_pkg::KIND_COL, j, col_shift[j],
                                           mpe_pkg::STATUS_OK, 0, 0, 0, 0, 1'b0));
         factor_queue.push_back(mk_word(mpe_pkg::KIND_SUM, 0, 0, mpe_pkg::STATUS_OK, 0, amax,
                                        rowcnd, clamp_exp(kmin) - clamp_exp(kmax), 1'b1));
      end
      clear_run();
   endtask

   task automatic cmp_field(input string name, input longint e, input longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_reg = 5'd16;
         cols_reg = 5'd16;
         fails = 0;
         clear_run();
         factor_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == 1'b0) begin
               rows_reg = csr_pwdata[4:0];
               clear_run();
            end else begin
               cols_reg = csr_pwdata[4:0];
               clear_run();
            end
         end
         if (req.valid && req.ready) take_element(req.re_bits, req.im_bits);
         if (rsp.valid && rsp.ready) begin
            if (factor_queue.size() == 0) begin
               $error("unexpected result word kind %0d index %0d", rsp.kind, rsp.index);
               fails++;
            end else begin
               factor_word w;
               w = factor_queue.pop_front();
               cmp_field("kind", w.kind, rsp.kind);
               cmp_field("index", w.index, rsp.index);
               cmp_field("scale_exp", w.scale_exp, rsp.scale_exp);
               cmp_field("status", w.status, rsp.status);
               cmp_field("bad_index", w.bad_index, rsp.bad_index);
               cmp_field("amax_exp", w.amax_exp, rsp.amax_exp);
               cmp_field("rowcnd_exp", w.rowcnd_exp, rsp.rowcnd_exp);
               cmp_field("colcnd_exp", w.colcnd_exp, rsp.colcnd_exp);
               cmp_field("last", w.last, rsp.last);
            end
         end
      end
   end
endmodule

// ----- sim/matrix_pow2_equilibration_tb.sv -----
// testbench top: clock, reset, matrix stimulus, csr writes and the verdict
module matrix_pow2_equilibration_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 310;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fails;
   int          pending;
   int          cycles = 0;
   int          words_sent;
   int          send_idle;
   int          recv_idle;
   int          rows_now;
   int          cols_now;

   mpe_req_if req ();
   mpe_rsp_if rsp ();

   matrix_pow2_equilibration dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   mpe_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fails(fails), .pending(pending)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[matrix_pow2_equilibration] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   function automatic int dim_of(input int v, input int mx);
      if (v < 1) return 1;
      if (v > mx) return mx;
      return v;
   endfunction

   function automatic logic [63:0] rand_double();
      logic [51:0] mant;
      logic        sgn;
      mant = 52'({$urandom, $urandom});
      sgn = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 15))
         0: return {sgn, 63'd0};
         1: return {sgn, 11'h7FF, 52'd0};
         2: return {sgn, 11'h7FF, mant | 52'd1};
         3: return {sgn, 11'd0, mant};
         4: return {$urandom, $urandom};
         5: return {sgn, 11'($urandom_range(0, 2046)), mant};
         6: return {sgn, 11'($urandom_range(2000, 2046)), mant};
         default: return {sgn, 11'($urandom_range(983, 1063)), mant};
      endcase
   endfunction

   task automatic send_word(input logic [63:0] re, input logic [63:0] im);
      while ($urandom_range(0, 99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.re_bits <= re;
      req.im_bits <= im;
      do @(posedge clock); while (!req.ready);
      words_sent++;
      if (words_sent < 110) begin
         send_idle = 10; recv_idle = 49;
      end else if (words_sent < 220) begin
         send_idle = 49; recv_idle = 10;
      end else begin
         send_idle = 0; recv_idle = 0;
      end
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // the block may still be finishing an element that yields no word
      repeat (8) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_dims(input int r, input int c);
      csr_write(3'd0, 32'(r) | ({$urandom} & 32'hFFFF_FFE0));
      csr_write(3'd4, 32'(c) | ({$urandom} & 32'hFFFF_FFE0));
      rows_now = dim_of(r & 31, mpe_pkg::ROWS_MAX);
      cols_now = dim_of(c & 31, mpe_pkg::COLS_MAX);
   endtask

   // mode 1 forces a zero row, mode 2 a zero column
   task automatic send_matrix(input int mode);
      int          zr;
      int          zc;
      logic [63:0] re;
      logic [63:0] im;
      zr = $urandom_range(0, rows_now - 1);
      zc = $urandom_range(0, cols_now - 1);
      for (int j = 0; j < cols_now; j++) begin
         for (int i = 0; i < rows_now; i++) begin
            if ((mode == 1 && i == zr) || (mode == 2 && j == zc)) begin
               re = {1'($urandom), 63'd0};
               im = ($urandom_range(0, 5) == 0) ? {1'b0, 11'h7FF, 52'h8_0000_0000_0000}
                                               : {1'($urandom), 63'd0};
            end else begin
               re = rand_double();
               im = rand_double();
            end
            send_word(re, im);
         end
      end
   endtask

   initial begin
      int mode;
      words_sent = 0;
      send_idle = 10;
      recv_idle = 49;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.re_bits <= '0;
      req.im_bits <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single elements: zero, infinity, nan, smallest denormal, largest finite, fractions
      set_dims(1, 1);
      send_word(64'h8000_0000_0000_0000, 64'h0);
      send_word(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
      send_word(64'h7FF8_0000_0000_0001, 64'h0);
      send_word(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
      send_word(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
      send_word(64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000);
      send_word(64'h3FE8_0000_0000_0000, 64'h0);
      send_word(64'hC008_0000_0000_0000, 64'h0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // zero second column
      set_dims(2, 2);
      send_word(64'h3FF0_0000_0000_0000, 64'h0);
      send_word(64'h4000_0000_0000_0000, 64'h0);
      send_word(64'h0, 64'h0);
      send_word(64'h0, 64'h8000_0000_0000_0000);
      // product underflows to zero in the column pass
      set_dims(1, 2);
      send_word(64'h7E70_0000_0000_0000, 64'h0);
      send_word(64'h0000_0000_0000_0001, 64'h0);
      // a row holding only nan counts as zero
      set_dims(2, 1);
      send_word(64'h7FF8_0000_0000_0000, 64'h0);
      send_word(64'h4014_0000_0000_0000, 64'h0);
      // abandoned run, then out-of-range dimensions
      set_dims(3, 3);
      send_word(rand_double(), rand_double());
      send_word(rand_double(), rand_double());
      set_dims(0, 20);
      send_matrix(0);

      while (words_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: set_dims(16, $urandom_range(1, 3));
            1: set_dims($urandom_range(1, 3), $urandom_range(16, 31));
            2: set_dims($urandom_range(0, 1), $urandom_range(0, 1));
            default: set_dims($urandom_range(1, 5), $urandom_range(1, 5));
         endcase
         repeat ($urandom_range(1, 3)) begin
            mode = $urandom_range(0, 9);
            if (words_sent < RANDOM_ITEMS) send_matrix(mode == 8 ? 1 : (mode == 9 ? 2 : 0));
         end
         if ($urandom_range(0, 15) == 0 && words_sent < RANDOM_ITEMS) begin
            // broken sequence: a few words, then the run is abandoned
            repeat ($urandom_range(1, 3)) send_word(rand_double(), rand_double());
            set_dims(rows_now, cols_now);
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fails == 0) $display("[matrix_pow2_equilibration] OK");
      else $display("[matrix_pow2_equilibration] ERROR");
      $finish;
   end
endmodule
